@@ src/btnf_pkg.sv @@
// Package for the boundary-tag next-fit heap allocator.
// Holds the controller-to-datapath command and status types; no dependencies.
package btnf_pkg;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_READ,
        CMD_WRITE
    } t_mem_op;

    typedef struct packed {
        t_mem_op     op;
        logic [15:0] addr;
        logic [31:0] wdata;
    } t_cmd;

    typedef struct packed {
        logic [31:0] rdata;
    } t_status;

    localparam logic [31:0] ALLOC_BIT = 32'h1;
    localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
    localparam logic [16:0] MIN_BLOCK = 17'd16;
    localparam logic [16:0] PROLOGUE_BP = 17'd8;
    localparam logic [16:0] FIRST_BP = 17'd16;

endpackage

@@ src/boundary_tag_next_fit_allocator.sv @@
// Top level of the boundary-tag next-fit heap allocator.
// Depends on btnf_pkg, btnf_ctrl and btnf_datapath.
//
// One item at a time: an allocate walks block headers from the rover, one
// memory read (through S_RD, S_RDW and S_RDW2) plus a decision step per
// block, then carves or grows the heap with a handful of single-word writes;
// a free walks from the prologue to validate the address, then merges.
// After reset a clearing pass writes one word per cycle, through the smaller of
// HEAP_BYTES and 64 KiB over four words, and so zeroes the store; the prologue,
// epilogue and first chunk are then built before the first transfer is
// accepted. The result transfer holds until taken, and no new input transfer
// is accepted while it waits.
module boundary_tag_next_fit_allocator #(
    parameter int unsigned HEAP_BYTES  = 65536,
    parameter int unsigned CHUNK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // request_bytes[15:0], block_address[31:16]
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // result_address[15:0]
    output logic        m_axis_tuser   // success
);
    import btnf_pkg::*;

    localparam int unsigned LIMIT  = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam int unsigned NWORDS = LIMIT / 4;

    t_cmd    w_cmd;
    t_status w_status;

    btnf_ctrl #(
        .LIMIT(LIMIT), .CHUNK(CHUNK_BYTES), .WALK(LIMIT / 8 + 4), .NWORDS(NWORDS)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_req(s_axis_tdata[15:0]),
        .i_baddr(s_axis_tdata[31:16]),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_res_addr(m_axis_tdata), .o_success(m_axis_tuser),
        .o_cmd(w_cmd), .i_status(w_status)
    );

    btnf_datapath #(.NWORDS(NWORDS)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .o_status(w_status)
    );
endmodule

@@ src/btnf_datapath.sv @@
// Datapath of the allocator: the heap word store with one port.
// Depends on btnf_pkg for the command and status types.
module btnf_datapath #(
    parameter int unsigned NWORDS = 16384
) (
    input  logic             i_clk,
    input  btnf_pkg::t_cmd   i_cmd,
    output btnf_pkg::t_status o_status
);
    import btnf_pkg::*;

    localparam int unsigned AW = $clog2(NWORDS);

    logic [31:0] r_mem [NWORDS];
    logic [31:0] r_rdata;
    logic [AW-1:0] w_idx;

    assign w_idx = i_cmd.addr[AW+1:2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_WRITE) begin
            r_mem[w_idx] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[w_idx];
    end

    assign o_status.rdata = r_rdata;
endmodule

@@ src/btnf_ctrl.sv @@
// Controller of the allocator: sequences memory accesses for clear, search,
// carve, grow, validate and merge. Depends on btnf_pkg.
module btnf_ctrl #(
    parameter int unsigned LIMIT = 65536,
    parameter int unsigned CHUNK = 4096,
    parameter int unsigned WALK  = 8196,
    parameter int unsigned NWORDS = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [15:0]       i_req,
    input  logic [15:0]       i_baddr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_res_addr,
    output logic              o_success,
    output btnf_pkg::t_cmd    o_cmd,
    input  btnf_pkg::t_status i_status
);
    import btnf_pkg::*;

    localparam int unsigned AW = $clog2(NWORDS);
    localparam logic [16:0] LIM = 17'(LIMIT);
    localparam logic [16:0] CHK = 17'(((CHUNK / 4 + 1) / 2) * 8);

    typedef enum logic [5:0] {
        S_CLR, S_INIT, S_IDLE,
        S_RD, S_RDW, S_RDW2,
        S_OUT
    } t_state;

    // Micro-op sequencer: each step reads a word (result into r_data), writes
    // one, or only decides, then continues at the step code in r_step.
    typedef enum logic [5:0] {
        P_INIT0, P_INIT1, P_INIT2, P_GROW0, P_GROW1, P_GROW2, P_GROW3,
        P_M0, P_M1, P_M2, P_M3, P_M4, P_M5, P_M6, P_M7,
        P_A0, P_S0, P_S1, P_S2, P_W0, P_W1, P_W2, P_W3, P_SF, P_EXT,
        P_C0, P_C1, P_C2, P_C3, P_C4,
        P_F0, P_F1, P_F2, P_F3, P_F4, P_F5, P_DONE
    } t_step;

    t_state r_state;
    t_step  r_step;
    logic [AW-1:0] r_clr;
    logic [16:0] r_rover, r_brk, r_asize, r_bp, r_p, r_start, r_size, r_nb, r_pb;
    logic [16:0] r_csize, r_nsize, r_psize;
    logic [16:0] r_n;
    logic        r_pa, r_na, r_kind, r_mrg_alloc;
    logic [15:0] r_b;
    logic [31:0] r_data;
    logic [15:0] r_addr;
    logic [31:0] r_wdata;
    logic        r_wr;
    logic [15:0] r_res;
    logic        r_ok;
    logic        r_pass2;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_res_addr = r_res;
    assign o_success = r_ok;

    always_comb begin
        o_cmd.op = CMD_NONE;
        o_cmd.addr = r_addr;
        o_cmd.wdata = r_wdata;
        if (r_state == S_CLR) begin
            o_cmd.op = CMD_WRITE;
            o_cmd.addr = 16'({r_clr, 2'b00});
            o_cmd.wdata = '0;
        end else if (r_state == S_RD) begin
            o_cmd.op = r_wr ? CMD_WRITE : CMD_READ;
        end
    end

    // grow size from a byte count: whole words, rounded up to an even word count (a multiple of 8)
    function automatic logic [16:0] rnd8(input logic [16:0] b);
        logic [16:0] w;
        w = b >> 2;
        if (w[0]) w = w + 17'd1;
        return {w[14:0], 2'b00};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_rover <= FIRST_BP;
            r_brk <= FIRST_BP;
            r_step <= P_INIT0;
            r_wr <= 1'b0;
            r_ok <= 1'b0;
            r_res <= '0;
            r_kind <= 1'b0;
            r_mrg_alloc <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NWORDS - 1)) begin
                        r_state <= S_INIT;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind <= i_kind;
                        r_b <= i_baddr;
                        r_ok <= 1'b0;
                        r_res <= '0;
                        r_n <= '0;
                        if (!i_kind) begin
                            if (i_req == 16'd0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_asize <= (i_req <= 16'd8) ? MIN_BLOCK :
                                    ((17'(i_req) + 17'd15) & ~17'd7);
                                r_step <= P_A0;
                                r_state <= S_INIT;
                            end
                        end else if (i_baddr == 16'd0) begin
                            r_ok <= 1'b1;
                            r_state <= S_OUT;
                        end else if (17'(i_baddr) == PROLOGUE_BP) begin
                            r_state <= S_OUT;
                        end else begin
                            r_p <= PROLOGUE_BP;
                            r_step <= P_F0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= r_wr ? S_INIT : S_RDW;
                end
                S_RDW: r_state <= S_RDW2;
                S_RDW2: begin
                    r_data <= i_status.rdata;
                    r_state <= S_INIT;
                end
                S_OUT: begin
                    if (i_out_ready) r_state <= S_IDLE;
                end
                default: begin
                    // S_INIT: execute one micro-step
                    r_state <= S_RD;
                    r_wr <= 1'b0;
                    case (r_step)
                        P_INIT0: begin
                            r_addr <= 16'd4; r_wdata <= 32'd9; r_wr <= 1'b1;
                            r_step <= P_INIT1;
                        end
                        P_INIT1: begin
                            r_addr <= 16'd8; r_wdata <= 32'd9; r_wr <= 1'b1;
                            r_step <= P_INIT2;
                        end
                        P_INIT2: begin
                            r_addr <= 16'd12; r_wdata <= 32'd1; r_wr <= 1'b1;
                            r_size <= CHK; r_mrg_alloc <= 1'b0;
                            r_step <= P_GROW0;
                        end
                        P_GROW0: begin
                            if (r_size == 17'd0 || 18'(r_brk) + 18'(r_size) > 18'(LIM)) begin
                                // A failed initial chunk leaves the heap empty.
                                r_state <= r_mrg_alloc ? S_INIT : S_IDLE;
                                r_step <= P_DONE;
                            end else begin
                                r_bp <= r_brk;
                                r_brk <= r_brk + r_size;
                                r_addr <= 16'(r_brk - 17'd4);
                                r_wdata <= 32'(r_size); r_wr <= 1'b1;
                                r_step <= P_GROW1;
                            end
                        end
                        P_GROW1: begin
                            r_addr <= 16'(r_bp + r_size - 17'd8);
                            r_wdata <= 32'(r_size); r_wr <= 1'b1;
                            r_step <= P_GROW2;
                        end
                        P_GROW2: begin
                            r_addr <= 16'(r_bp + r_size - 17'd4);
                            r_wdata <= 32'd1; r_wr <= 1'b1;
                            r_step <= P_M0;
                        end
                        // merge(r_bp), r_size holds its size
                        P_M0: begin
                            r_addr <= 16'(r_bp - 17'd8); r_step <= P_M1;
                        end
                        P_M1: begin
                            r_pa <= r_data[0];
                            r_psize <= 17'(r_data & SIZE_MASK);
                            r_nb <= r_bp + r_size;
                            r_addr <= 16'(r_bp + r_size - 17'd4); r_step <= P_M2;
                        end
                        P_M2: begin
                            r_na <= r_data[0];
                            r_nsize <= 17'(r_data & SIZE_MASK);
                            r_state <= S_INIT; r_step <= P_M3;
                        end
                        P_M3: begin
                            r_pb <= r_bp - r_psize;
                            if (r_pa && r_na) begin
                                r_state <= S_INIT; r_step <= P_M7;
                            end else if (r_pa) begin
                                r_addr <= 16'(r_bp - 17'd4);
                                r_wdata <= 32'(r_size + r_nsize); r_wr <= 1'b1;
                                r_step <= P_M4;
                            end else begin
                                // previous header has same size as its footer
                                r_addr <= 16'(r_bp - r_psize - 17'd4);
                                r_wdata <= 32'(r_size + r_psize + (r_na ? 17'd0 : r_nsize));
                                r_wr <= 1'b1;
                                r_step <= P_M5;
                            end
                        end
                        P_M4: begin
                            r_addr <= 16'(r_bp + r_size + r_nsize - 17'd8);
                            r_wr <= 1'b1; r_step <= P_M6;
                        end
                        P_M5: begin
                            r_addr <= 16'(r_na ? (r_bp + r_size - 17'd8)
                                              : (r_nb + r_nsize - 17'd8));
                            r_wr <= 1'b1;
                            r_bp <= r_pb;
                            r_step <= P_M6;
                        end
                        P_M6: begin
                            r_rover <= r_bp;
                            r_state <= S_INIT; r_step <= P_M7;
                        end
                        P_M7: begin
                            r_state <= S_INIT;
                            if (!r_mrg_alloc) begin
                                r_state <= S_IDLE;
                                if (r_kind) begin
                                    r_ok <= 1'b1; r_state <= S_OUT;
                                end
                            end else begin
                                r_step <= P_C0;
                            end
                        end
                        // allocate: next-fit search
                        P_A0: begin
                            r_start <= r_rover; r_p <= r_rover; r_pass2 <= 1'b0;
                            r_addr <= 16'(r_rover - 17'd4); r_step <= P_S0;
                        end
                        P_S0: begin
                            r_csize <= 17'(r_data & SIZE_MASK);
                            r_state <= S_INIT;
                            if (!r_pass2 && ((r_data & SIZE_MASK) == 0 || r_n >= 17'(WALK))) begin
                                r_pass2 <= 1'b1; r_p <= PROLOGUE_BP;
                                r_step <= P_S2;
                            end else if (r_pass2 && (r_p >= r_start || r_n >= 17'(WALK))) begin
                                r_step <= P_EXT;
                            end else if (!r_data[0] && r_asize <= 17'(r_data & SIZE_MASK)) begin
                                r_rover <= r_p; r_bp <= r_p; r_step <= P_C0;
                            end else if (r_pass2 && (r_data & SIZE_MASK) == 0) begin
                                r_step <= P_EXT;
                            end else begin
                                r_p <= r_p + 17'(r_data & SIZE_MASK);
                                r_n <= r_n + 17'd1;
                                r_step <= P_S2;
                            end
                        end
                        P_S2: begin
                            r_addr <= 16'(r_p - 17'd4); r_step <= P_S0;
                        end
                        P_EXT: begin
                            r_rover <= r_start;
                            r_size <= rnd8((r_asize > 17'(CHUNK)) ? r_asize : 17'(CHUNK));
                            r_mrg_alloc <= 1'b1;
                            r_state <= S_INIT; r_step <= P_GROW0;
                        end
                        P_DONE: begin
                            r_state <= S_OUT;
                        end
                        // carve r_bp
                        P_C0: begin
                            r_addr <= 16'(r_bp - 17'd4); r_step <= P_C1;
                        end
                        P_C1: begin
                            r_csize <= 17'(r_data & SIZE_MASK);
                            r_addr <= 16'(r_bp - 17'd4);
                            if (17'(r_data & SIZE_MASK) - r_asize >= MIN_BLOCK) begin
                                r_wdata <= 32'(r_asize) | ALLOC_BIT;
                            end else begin
                                r_wdata <= (r_data & SIZE_MASK) | ALLOC_BIT;
                            end
                            r_wr <= 1'b1; r_step <= P_C2;
                        end
                        P_C2: begin
                            r_wr <= 1'b1;
                            if (r_csize - r_asize >= MIN_BLOCK) begin
                                r_addr <= 16'(r_bp + r_asize - 17'd8);
                                r_step <= P_C3;
                            end else begin
                                r_addr <= 16'(r_bp + r_csize - 17'd8);
                                r_step <= P_F5;
                            end
                        end
                        P_C3: begin
                            r_addr <= 16'(r_bp + r_asize - 17'd4);
                            r_wdata <= 32'(r_csize - r_asize); r_wr <= 1'b1;
                            r_step <= P_C4;
                        end
                        P_C4: begin
                            r_addr <= 16'(r_bp + r_csize - 17'd8);
                            r_wr <= 1'b1; r_step <= P_F5;
                        end
                        P_F5: begin
                            r_res <= r_bp[15:0]; r_ok <= 1'b1;
                            r_state <= S_OUT;
                        end
                        // free: walk from prologue to validate
                        P_F0: begin
                            r_addr <= 16'(r_p - 17'd4); r_step <= P_F1;
                        end
                        P_F1: begin
                            r_state <= S_INIT;
                            if ((r_data & SIZE_MASK) == 0 || r_n >= 17'(WALK)) begin
                                r_state <= S_OUT;
                            end else if (r_p == 17'(r_b)) begin
                                r_bp <= r_p; r_size <= 17'(r_data & SIZE_MASK);
                                r_step <= P_F2;
                            end else begin
                                r_p <= r_p + 17'(r_data & SIZE_MASK);
                                r_n <= r_n + 17'd1;
                                r_step <= P_F0;
                            end
                        end
                        P_F2: begin
                            r_addr <= 16'(r_bp - 17'd4);
                            r_wdata <= 32'(r_size); r_wr <= 1'b1; r_step <= P_F3;
                        end
                        P_F3: begin
                            r_addr <= 16'(r_bp + r_size - 17'd8);
                            r_wr <= 1'b1; r_mrg_alloc <= 1'b0; r_step <= P_M0;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end
endmodule

@@ src/btnf_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
// No package dependencies.
module btnf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == 16'd0)
        else $error("failed result with address");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule

bind boundary_tag_next_fit_allocator btnf_checker u_chk (.*);

@@ verif/tb_boundary_tag_next_fit_allocator.sv @@
// Self-checking testbench for the boundary-tag next-fit heap allocator.
// Depends on btnf_pkg and boundary_tag_next_fit_allocator; holds its own heap mirror as predictor.
`timescale 1ns / 1ps

module tb_boundary_tag_next_fit_allocator;

    import btnf_pkg::*;

    localparam int unsigned HEAP_SIZE   = 65536;
    localparam int unsigned GROW_BYTES  = 4096;
    localparam int unsigned HEAP_TOP    = (HEAP_SIZE < 65536) ? HEAP_SIZE : 65536;
    localparam int unsigned NUM_WORDS   = HEAP_TOP / 4;
    localparam int unsigned MAX_WALK    = HEAP_TOP / 8 + 4;
    localparam int unsigned MIN_SIZE    = 16;
    localparam int unsigned PRO_OFFSET  = 8;
    localparam int unsigned FIRST_OFFSET = 16;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned IDLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD   = 3000;
    localparam int unsigned DRAIN_CYCLES = 200;

    // Operation selector carried on the input tuser bit.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct {
        logic        kind;
        logic [15:0] req_bytes;
        logic [15:0] blk_addr;
        logic [15:0] want_addr;
        logic        want_ok;
    } t_heap_op;

    typedef struct {
        logic [15:0] addr;
        logic        ok;
    } t_alloc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;   // request_bytes[15:0], block_address[31:16]
    logic        s_user;   // kind
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_data;   // result_address[15:0]
    logic        m_user;   // success

    boundary_tag_next_fit_allocator #(
        .HEAP_BYTES (HEAP_SIZE),
        .CHUNK_BYTES(GROW_BYTES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .s_axis_tuser (s_user),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),
        .m_axis_tuser (m_user)
    );

    // ------------------------------------------------------------------
    // Heap mirror. The store, rover and break follow the block exactly;
    // the stimulus generator runs every item through it up front, so each
    // pending item already carries the result the block must return.
    // ------------------------------------------------------------------
    int unsigned heap_mirror [NUM_WORDS];
    int unsigned rover_mirror;
    int unsigned break_mirror;

    function automatic int unsigned word_at(int unsigned a);
        return heap_mirror[(a / 4) % NUM_WORDS];
    endfunction

    function automatic void put_word(int unsigned a, int unsigned v);
        heap_mirror[(a / 4) % NUM_WORDS] = v;
    endfunction

    function automatic int unsigned size_at(int unsigned a);
        return word_at(a) & ~32'd7;
    endfunction

    function automatic int unsigned used_at(int unsigned a);
        return word_at(a) & 32'd1;
    endfunction

    // Joins a free block with whichever neighbors are free; all four
    // neighbor combinations are handled and the rover lands on the result unless both neighbors are used.
    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned sz;
        int unsigned nb;
        int unsigned pb;
        int unsigned nfoot;
        logic        prev_used;
        logic        next_used;
        sz = size_at(bp - 4);
        nb = bp + sz;
        prev_used = used_at(bp - 8);
        next_used = used_at(nb - 4);
        if (prev_used && next_used) return bp;
        if (prev_used) begin
            sz += size_at(nb - 4);
            put_word(bp - 4, sz);
            put_word(bp + sz - 8, sz);
        end else if (next_used) begin
            pb = bp - size_at(bp - 8);
            sz += size_at(pb - 4);
            put_word(bp + size_at(bp - 4) - 8, sz);
            put_word(pb - 4, sz);
            bp = pb;
        end else begin
            pb = bp - size_at(bp - 8);
            nfoot = nb + size_at(nb - 4) - 8;
            sz += size_at(pb - 4) + size_at(nb - 4);
            put_word(pb - 4, sz);
            put_word(nfoot, sz);
            bp = pb;
        end
        rover_mirror = bp;
        return bp;
    endfunction

    function automatic int unsigned grow_mirror(int unsigned bytes);
        int unsigned words;
        int unsigned sz;
        int unsigned bp;
        words = bytes / 4;
        if (words & 1) words++;
        sz = words * 4;
        if (sz == 0 || break_mirror + sz > HEAP_TOP) return 0;
        bp = break_mirror;
        break_mirror += sz;
        put_word(bp - 4, sz);
        put_word(bp + sz - 8, sz);
        put_word(bp + sz - 4, 1);
        return coalesce(bp);
    endfunction

    function automatic logic block_fits(int unsigned p, int unsigned need);
        return used_at(p - 4) == 0 && need <= size_at(p - 4);
    endfunction

    // Next-fit: rover to the epilogue, then once from the prologue up to the rover.
    function automatic int unsigned scan_for_fit(int unsigned need);
        int unsigned start;
        int unsigned p;
        int unsigned n;
        start = rover_mirror;
        p = start;
        n = 0;
        while (size_at(p - 4) > 0 && n < MAX_WALK) begin
            if (block_fits(p, need)) begin
                rover_mirror = p;
                return p;
            end
            p = p + size_at(p - 4);
            n++;
        end
        p = PRO_OFFSET;
        while (p < start && n < MAX_WALK) begin
            if (block_fits(p, need)) begin
                rover_mirror = p;
                return p;
            end
            if (size_at(p - 4) == 0) break;
            p = p + size_at(p - 4);
            n++;
        end
        rover_mirror = start;
        return 0;
    endfunction

    function automatic void place_block(int unsigned bp, int unsigned need);
        int unsigned have;
        have = size_at(bp - 4);
        if (have - need >= MIN_SIZE) begin
            put_word(bp - 4, need | 1);
            put_word(bp + need - 8, need | 1);
            put_word(bp + need - 4, have - need);
            put_word(bp + have - 8, have - need);
        end else begin
            put_word(bp - 4, have | 1);
            put_word(bp + have - 8, have | 1);
        end
    endfunction

    function automatic logic is_heap_block(int unsigned b);
        int unsigned p;
        int unsigned n;
        p = PRO_OFFSET;
        n = 0;
        while (size_at(p - 4) > 0 && n < MAX_WALK) begin
            if (p == b) return 1'b1;
            p = p + size_at(p - 4);
            n++;
        end
        return 1'b0;
    endfunction

    function automatic void reset_heap_mirror();
        int unsigned unused;
        foreach (heap_mirror[k]) heap_mirror[k] = 0;
        put_word(4, 8 | 1);
        put_word(8, 8 | 1);
        put_word(12, 1);
        break_mirror = FIRST_OFFSET;
        rover_mirror = FIRST_OFFSET;
        unused = grow_mirror(GROW_BYTES);
    endfunction

    function automatic t_alloc_result apply_heap_op(logic kind, logic [15:0] req,
                                                    logic [15:0] addr);
        t_alloc_result res;
        int unsigned   need;
        int unsigned   bp;
        int unsigned   sz;
        res.addr = '0;
        res.ok   = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (req == 0) return res;
            need = (req <= 8) ? MIN_SIZE : 8 * ((int'(req) + 15) / 8);
            bp = scan_for_fit(need);
            if (bp == 0) begin
                bp = grow_mirror((need > GROW_BYTES) ? need : GROW_BYTES);
                if (bp == 0) return res;
            end
            place_block(bp, need);
            res.addr = bp[15:0];
            res.ok   = 1'b1;
        end else begin
            if (addr == 0) begin
                res.ok = 1'b1;
                return res;
            end
            if (addr == PRO_OFFSET || !is_heap_block(addr)) return res;
            sz = size_at(addr - 4);
            put_word(addr - 4, sz);
            put_word(addr + sz - 8, sz);
            bp = coalesce(addr);
            res.ok = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus. Items are generated in order and predicted as they are made;
    // live_blocks tracks addresses handed out so most frees hit real blocks.
    // ------------------------------------------------------------------
    t_heap_op    pending_ops[$];
    t_heap_op    awaited_results[$];
    int unsigned live_blocks[$];
    int unsigned dead_blocks[$];
    logic        failed;
    int unsigned accepted_in;
    int unsigned idle_cycles;

    task automatic queue_op(logic kind, logic [15:0] req, logic [15:0] addr);
        t_heap_op      op;
        t_alloc_result res;
        res = apply_heap_op(kind, req, addr);
        op.kind      = kind;
        op.req_bytes = req;
        op.blk_addr  = addr;
        op.want_addr = res.addr;
        op.want_ok   = res.ok;
        pending_ops.push_back(op);
        if (kind == KIND_ALLOC && res.ok) live_blocks.push_back(res.addr);
    endtask

    task automatic free_live(int unsigned idx);
        int unsigned a;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        dead_blocks.push_back(a);
        queue_op(KIND_FREE, 16'h0, a[15:0]);
    endtask

    initial begin
        int unsigned roll;
        int unsigned req;
        int unsigned k;
        failed = 1'b0;
        reset_heap_mirror();

        // Directed part: rounding edges, a zero request, an oversized request,
        // ignored and rejected frees, a double free and every coalescing case.
        queue_op(KIND_ALLOC, 16'd0, 16'h0);
        queue_op(KIND_ALLOC, 16'd1, 16'h0);
        queue_op(KIND_ALLOC, 16'd8, 16'h0);
        queue_op(KIND_ALLOC, 16'd9, 16'h0);
        queue_op(KIND_ALLOC, 16'd24, 16'h0);
        queue_op(KIND_ALLOC, 16'hFFFF, 16'hFFFF);
        queue_op(KIND_FREE, 16'hFFFF, 16'h0);
        queue_op(KIND_FREE, 16'h0, 16'h8);
        queue_op(KIND_FREE, 16'h0, 16'h3);
        queue_op(KIND_FREE, 16'h0, 16'hFFFF);
        free_live(1);                       // both neighbors allocated
        queue_op(KIND_FREE, 16'h0, dead_blocks[0][15:0]);   // already free
        free_live(0);                       // next neighbor free
        free_live(0);                       // previous neighbor free
        queue_op(KIND_ALLOC, 16'd100, 16'h0);
        queue_op(KIND_ALLOC, 16'd100, 16'h0);
        queue_op(KIND_ALLOC, 16'd100, 16'h0);
        free_live(live_blocks.size() - 3);
        free_live(live_blocks.size() - 1);
        free_live(live_blocks.size() - 1);  // both neighbors free
        queue_op(KIND_ALLOC, 16'd5000, 16'h0);   // forces the heap to grow
        for (k = 0; k < 4; k++) queue_op(KIND_ALLOC, 16'd20000, 16'h0);  // runs out of heap

        // Random part: mostly small allocate/free traffic with a bounded number
        // of live blocks, plus some noise frees and rare huge requests.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (live_blocks.size() > 0 && (roll < 40 || live_blocks.size() > 48)) begin
                free_live($urandom_range(0, live_blocks.size() - 1));
            end else if (roll < 44) begin
                queue_op(KIND_FREE, 16'($urandom), 16'($urandom));
            end else if (roll < 46 && dead_blocks.size() > 0) begin
                queue_op(KIND_FREE, 16'h0,
                         dead_blocks[$urandom_range(0, dead_blocks.size() - 1)][15:0]);
            end else if (roll < 47) begin
                queue_op(KIND_FREE, 16'($urandom), 16'h0);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70)      req = $urandom_range(1, 256);
                else if (roll < 95) req = $urandom_range(257, 3000);
                else if (roll < 98) req = $urandom_range(3001, 24000);
                else                req = $urandom_range(0, 65535);
                queue_op(KIND_ALLOC, 16'(req), 16'($urandom));
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A transfer
    // happens when valid and ready are both high at the edge; the next item
    // is loaded in the same edge so valid can stay high across items.
    // ------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge i_clk) begin
        t_heap_op op;
        if (!i_rst_n) begin
            s_valid     <= 1'b0;
            s_data      <= '0;
            s_user      <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
            accepted_in <= 0;
        end else begin
            if (s_valid && s_ready) begin
                op = pending_ops.pop_front();
                awaited_results.push_back(op);
                accepted_in <= accepted_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= {pending_ops[0].blk_addr, pending_ops[0].req_bytes};
                    s_user  <= pending_ops[0].kind;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: alternates between always-ready and choppy stretches, and
    // once holds ready low for a long stretch so the block backs up.
    // ------------------------------------------------------------------
    int unsigned phase_left;
    int unsigned hold_left;
    logic        choppy;
    logic        long_hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready        <= 1'b0;
            phase_left     <= 0;
            hold_left      <= 0;
            choppy         <= 1'b0;
            long_hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!long_hold_done && accepted_in >= 300) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left <= $urandom_range(16, 200);
                choppy     <= 1'($urandom_range(0, 1));
            end else begin
                phase_left <= phase_left - 1;
            end
            m_ready <= choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    // Monitor: every result transfer is matched against the oldest item taken.
    always @(posedge i_clk) begin
        t_heap_op op;
        if (i_rst_n && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: actual addr=%h success=%b",
                         $time, m_data, m_user);
                failed = 1'b1;
            end else begin
                op = awaited_results.pop_front();
                if (m_data !== op.want_addr) begin
                    $display("%0t: result_address mismatch: expected %h actual %h",
                             $time, op.want_addr, m_data);
                    failed = 1'b1;
                end
                if (m_user !== op.want_ok) begin
                    $display("%0t: success mismatch: expected %b actual %b",
                             $time, op.want_ok, m_user);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either side. The limit covers
    // the clearing pass after reset, a full-heap walk and the long receiver hold.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_rst_n);
        @(posedge i_clk);
        wait (pending_ops.size() == 0 && !s_valid && awaited_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && awaited_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
